@@ hdl/sre_pkg.sv @@
// Shared types and constants for the settings request exchange.
// Used by the front, queue, back and top-level modules; no dependencies.
package sre_pkg;

	localparam int AddrW = 48;
	localparam int TimeW = 32;
	localparam int CountW = 32;

	typedef enum logic [2:0] {
		OP_ANNOUNCE = 3'd0,
		OP_REQUEST  = 3'd1,
		OP_PROCESS  = 3'd2,
		OP_POLL     = 3'd3,
		OP_DONE     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_SESSION  = 2'd0,
		CFG_CAPMASK  = 2'd1,
		CFG_TIMEOUT  = 2'd2,
		CFG_RETRY    = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNSUPP  = 2'd1;
	localparam logic [1:0] ST_BUSY    = 2'd2;
	localparam logic [1:0] ST_STORERR = 2'd3;

	localparam logic [1:0] OUT_OK   = 2'd0;
	localparam logic [1:0] OUT_BUSY = 2'd1;

	localparam logic [31:0] TimeoutRst = 32'd2500;
	localparam logic [31:0] RetryRst   = 32'd20;

	typedef struct packed {
		logic [31:0] session;
		logic [31:0] client;
		logic [31:0] sequence_n;
		logic [1:0]  mask;
		logic [7:0]  intensity;
		logic [7:0]  level;
		logic [1:0]  status;
	} rec_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [47:0] peer_address;
		logic [31:0] now_ms;
		logic        decode_ok;
		logic [31:0] req_session;
		logic [31:0] client;
		logic [31:0] sequence_req;
		logic [1:0]  change_mask;
		logic [7:0]  intensity;
		logic [7:0]  level;
		logic [1:0]  store_outcome;
		logic        send_success;
	} item_t;

	// Classified event handed from front to back.
	typedef struct packed {
		item_t       item;
		logic        is_valid_op;
	} cls_t;

	typedef struct packed {
		logic        accepted;
		logic        reply_posted;
		logic        reply_ready;
		logic [47:0] reply_peer;
		rec_t        rec;
	} res_t;

	localparam int ClsW = $bits(cls_t);
	localparam int ResW = $bits(res_t);

endpackage

@@ hdl/sre_front.sv @@
// Front end: accepts input requests, registers them, precomputes op validity.
// Depends on sre_pkg.
module sre_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  sre_pkg::item_t          in_item,
	output logic                    q_valid,
	input  logic                    q_ready,
	output sre_pkg::cls_t           q_data
);
	logic           valid_s1;
	sre_pkg::cls_t  data_s1;

	assign in_ready = !valid_s1 || q_ready;
	assign q_valid = valid_s1;
	assign q_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.item <= in_item;
			data_s1.is_valid_op <= (in_item.op <= 3'(sre_pkg::OP_DONE));
		end
	end
endmodule

@@ hdl/sre_queue.sv @@
// Two-entry queue between front and back.
// Depends on sre_pkg.
module sre_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  sre_pkg::cls_t        wr_data,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output sre_pkg::cls_t        rd_data
);
	sre_pkg::cls_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          wr_en, rd_en;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule

@@ hdl/sre_back.sv @@
// Back end: holds exchange state and executes each event into a result.
// Depends on sre_pkg.
module sre_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	output logic                 ev_ready,
	input  sre_pkg::cls_t        ev_data,
	input  logic [31:0]          session_id,
	input  logic [1:0]           capability_mask,
	input  logic [15:0]          peer_timeout_ms,
	input  logic [15:0]          retry_interval_ms,
	output logic                 res_valid,
	input  logic                 res_ready,
	output sre_pkg::res_t        res_data
);
	logic [47:0]  peer_addr_q;
	logic         peer_known_q;
	logic [31:0]  peer_seen_at_q;
	sre_pkg::rec_t newest_q, done_reply_q, out_reply_q;
	logic         req_wait_q, done_valid_q, reply_wait_q, reply_tried_q;
	logic [31:0]  done_client_q, done_seq_q;
	logic [31:0]  reply_count_q, in_flight_q, sent_at_q;
	logic [7:0]   st_int_q, st_lvl_q;

	logic          res_v_q;
	sre_pkg::res_t res_q;

	sre_pkg::item_t it;
	logic          go, fresh, acc, pending, dup, avail, differ;
	logic [31:0]   d_seq, age, since;
	logic [1:0]    changed;
	sre_pkg::rec_t rq, res;
	sre_pkg::res_t nres;
	logic [7:0]    n_int, n_lvl;

	assign ev_ready = !res_v_q || res_ready;
	assign go = ev_valid && ev_ready;
	assign it = ev_data.item;
	assign res_valid = res_v_q;
	assign res_data = res_q;

	always_comb begin
		age = it.now_ms - peer_seen_at_q;
		since = it.now_ms - sent_at_q;
		fresh = peer_known_q && (age < {16'd0, peer_timeout_ms});
		rq = '{session: it.req_session, client: it.client, sequence_n: it.sequence_req,
			mask: it.change_mask, intensity: it.intensity, level: it.level, status: 2'd0};
		acc = it.decode_ok && peer_known_q && (it.peer_address == peer_addr_q) && fresh
			&& (it.req_session == session_id);
		if (acc && rq.client != newest_q.client && rq.mask != 2'd0) acc = 1'b0;
		d_seq = rq.sequence_n - newest_q.sequence_n;
		differ = rq.mask != newest_q.mask || rq.intensity != newest_q.intensity
			|| rq.level != newest_q.level;
		if (acc && rq.client == newest_q.client && newest_q.sequence_n != 32'd0
			&& (d_seq[31] || (d_seq == 32'd0 && differ))) acc = 1'b0;
		pending = req_wait_q && fresh;
		dup = done_valid_q && newest_q.client == done_client_q
			&& newest_q.sequence_n == done_seq_q && done_reply_q.status != sre_pkg::ST_BUSY;
		changed = newest_q.mask;
		if (newest_q.intensity == st_int_q) changed[0] = 1'b0;
		if (newest_q.level == st_lvl_q) changed[1] = 1'b0;
		n_int = st_int_q;
		n_lvl = st_lvl_q;
		res = newest_q;
		res.status = sre_pkg::ST_OK;
		if (changed != 2'd0) begin
			if ((capability_mask & changed) != changed) res.status = sre_pkg::ST_UNSUPP;
			else if (it.store_outcome == sre_pkg::OUT_OK) begin
				if (changed[0]) n_int = newest_q.intensity;
				if (changed[1]) n_lvl = newest_q.level;
			end else if (it.store_outcome == sre_pkg::OUT_BUSY) res.status = sre_pkg::ST_BUSY;
			else res.status = sre_pkg::ST_STORERR;
		end
		res.intensity = n_int;
		res.level = n_lvl;
		if (dup) res = done_reply_q;
		avail = reply_wait_q && fresh && (!reply_tried_q || since >= {16'd0, retry_interval_ms});
		nres = '0;
		case (it.op)
			3'(sre_pkg::OP_REQUEST): nres.accepted = acc;
			3'(sre_pkg::OP_PROCESS): if (pending) begin
				nres.reply_posted = 1'b1;
				nres.reply_peer = peer_addr_q;
				nres.rec = res;
			end
			3'(sre_pkg::OP_POLL): if (avail) begin
				nres.reply_ready = 1'b1;
				nres.reply_peer = peer_addr_q;
				nres.rec = out_reply_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			res_q <= '0;
			peer_addr_q <= '0; peer_known_q <= 1'b0; peer_seen_at_q <= '0;
			newest_q <= '0; done_reply_q <= '0; out_reply_q <= '0;
			req_wait_q <= 1'b0; done_valid_q <= 1'b0;
			reply_wait_q <= 1'b0; reply_tried_q <= 1'b0;
			done_client_q <= '0; done_seq_q <= '0;
			reply_count_q <= '0; in_flight_q <= '0; sent_at_q <= '0;
			st_int_q <= '0; st_lvl_q <= '0;
		end else begin
			if (ev_ready) res_v_q <= go;
			if (go) res_q <= nres;
			if (go && ev_data.is_valid_op) begin
				case (it.op)
					3'(sre_pkg::OP_ANNOUNCE): begin
						if (peer_known_q && peer_addr_q != it.peer_address) begin
							req_wait_q <= 1'b0; done_valid_q <= 1'b0;
							reply_wait_q <= 1'b0; newest_q <= '0;
						end
						peer_addr_q <= it.peer_address;
						peer_known_q <= 1'b1;
						peer_seen_at_q <= it.now_ms;
					end
					3'(sre_pkg::OP_REQUEST): if (acc) begin
						newest_q <= rq;
						req_wait_q <= 1'b1;
					end
					3'(sre_pkg::OP_PROCESS): begin
						req_wait_q <= 1'b0;
						if (pending) begin
							if (!dup) begin
								st_int_q <= n_int;
								st_lvl_q <= n_lvl;
							end
							done_client_q <= newest_q.client;
							done_seq_q <= newest_q.sequence_n;
							done_reply_q <= res;
							done_valid_q <= 1'b1;
							out_reply_q <= res;
							reply_wait_q <= 1'b1;
							reply_count_q <= reply_count_q + 32'd1;
						end
					end
					3'(sre_pkg::OP_POLL): if (avail) begin
						in_flight_q <= reply_count_q;
						sent_at_q <= it.now_ms;
						reply_tried_q <= 1'b1;
					end
					3'(sre_pkg::OP_DONE):
						if (it.send_success && in_flight_q == reply_count_q)
							reply_wait_q <= 1'b0;
					default: ;
				endcase
			end
		end
	end
endmodule

@@ hdl/settings_request_exchange.sv @@
// Top level of the settings request exchange: config registers, front, queue, back.
// Depends on sre_pkg, sre_front, sre_queue, sre_back.
//
// channel  | direction | handshake             | payload
// s_axis   | in        | s_axis_tvalid/tready  | event request (op in tuser)
// m_axis   | out       | m_axis_tvalid/tready  | one result per event
// cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One event per cycle sustained while m_axis_tready stays high; a result passes the
// front register, the queue and the back end result register; stalls can hold it in each.
// Back end state updates in the same cycle an event leaves the queue.
// Reset clears valid flags, pointers and back end state; restores register defaults.
// Output stalls back up through the queue to s_axis_tready.
module settings_request_exchange (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [199:0] s_axis_tdata, // peer_address, now_ms, decode_ok, req_session,
	                                   // client, sequence_req, change_mask, intensity,
	                                   // level, store_outcome, send_success, pad
	input  logic [2:0]   s_axis_tuser, // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [167:0] m_axis_tdata, // accepted, reply_posted, reply_ready, reply_peer,
	                                   // reply_session, reply_client, reply_sequence,
	                                   // reply_mask, reply_intensity, reply_level,
	                                   // reply_status, pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	logic [31:0] session_q;
	logic [1:0]  cap_q;
	logic [15:0] timeout_q, retry_q;

	sre_pkg::item_t item;
	sre_pkg::cls_t  f_data, q_data;
	sre_pkg::res_t  r;
	logic           f_valid, f_ready, q_valid, q_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= '0;
			cap_q <= 2'd3;
			timeout_q <= sre_pkg::TimeoutRst[15:0];
			retry_q <= sre_pkg::RetryRst[15:0];
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sre_pkg::CFG_SESSION: session_q <= cfg_data;
				sre_pkg::CFG_CAPMASK: cap_q <= cfg_data[1:0];
				sre_pkg::CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
				sre_pkg::CFG_RETRY:   retry_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign item.op            = s_axis_tuser;
	assign item.peer_address  = s_axis_tdata[47:0];
	assign item.now_ms        = s_axis_tdata[79:48];
	assign item.decode_ok     = s_axis_tdata[80];
	assign item.req_session   = s_axis_tdata[112:81];
	assign item.client        = s_axis_tdata[144:113];
	assign item.sequence_req  = s_axis_tdata[176:145];
	assign item.change_mask   = s_axis_tdata[178:177];
	assign item.intensity     = s_axis_tdata[186:179];
	assign item.level         = s_axis_tdata[194:187];
	assign item.store_outcome = s_axis_tdata[196:195];
	assign item.send_success  = s_axis_tdata[197];

	sre_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(item),
		.q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
	);

	sre_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	sre_back u_back (
		.clk(clk), .arst_n(arst_n),
		.ev_valid(q_valid), .ev_ready(q_ready), .ev_data(q_data),
		.session_id(session_q), .capability_mask(cap_q),
		.peer_timeout_ms(timeout_q), .retry_interval_ms(retry_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(r)
	);

	assign m_axis_tdata = {1'd0, r.rec.status, r.rec.level, r.rec.intensity, r.rec.mask,
		r.rec.sequence_n, r.rec.client, r.rec.session, r.reply_peer,
		r.reply_ready, r.reply_posted, r.accepted};
endmodule

@@ hdl/sre_checker.sv @@
// Port-level checker for settings_request_exchange, bound to the top level.
// Depends only on the top-level ports.
module sre_port_props (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [167:0] m_axis_tdata,
	input logic         cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
		else $error("more than one result flag set");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] && !m_axis_tdata[2] |-> m_axis_tdata[167:3] == '0)
		else $error("reply fields set without reply");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port stalled");
endmodule

bind settings_request_exchange sre_port_props u_sre_port_props (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .cfg_ready(cfg_ready)
);

@@ test/sre_checker.sv @@
// Checker for the settings request exchange: watches the event, result and
// register channels, predicts every result and compares it field by field.
// Depends on sre_pkg.
module sre_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_valid,
	input  logic         s_ready,
	input  logic [199:0] s_data,
	input  logic [2:0]   s_user,
	input  logic         m_valid,
	input  logic         m_ready,
	input  logic [167:0] m_data,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           n_accepted,
	output int           n_posted,
	output int           n_ready
);

	logic [31:0] session_reg;
	logic [1:0]  cap_reg;
	logic [15:0] timeout_reg;
	logic [15:0] retry_reg;

	logic [47:0]   peer_addr;
	logic          peer_known;
	logic [31:0]   peer_seen_at;
	sre_pkg::rec_t newest;
	logic          req_waiting;
	logic          done_valid;
	logic [31:0]   done_client;
	logic [31:0]   done_seq;
	sre_pkg::rec_t done_reply;
	sre_pkg::rec_t out_reply;
	logic          reply_waiting;
	logic          reply_tried;
	logic [31:0]   reply_count;
	logic [31:0]   reply_in_flight;
	logic [31:0]   reply_sent_at;
	logic [7:0]    stored_int;
	logic [7:0]    stored_lvl;

	sre_pkg::res_t expected_results[$];

	function automatic logic peer_fresh(logic [31:0] now);
		logic [31:0] age;
		age = now - peer_seen_at;
		return peer_known && (age < {16'd0, timeout_reg});
	endfunction

	function automatic sre_pkg::item_t unpack_event(logic [199:0] d, logic [2:0] u);
		sre_pkg::item_t it;
		it.op            = u;
		it.peer_address  = d[47:0];
		it.now_ms        = d[79:48];
		it.decode_ok     = d[80];
		it.req_session   = d[112:81];
		it.client        = d[144:113];
		it.sequence_req  = d[176:145];
		it.change_mask   = d[178:177];
		it.intensity     = d[186:179];
		it.level         = d[194:187];
		it.store_outcome = d[196:195];
		it.send_success  = d[197];
		return it;
	endfunction

	function automatic sre_pkg::res_t unpack_result(logic [167:0] d);
		sre_pkg::res_t r;
		r.accepted         = d[0];
		r.reply_posted     = d[1];
		r.reply_ready      = d[2];
		r.reply_peer       = d[50:3];
		r.rec.session      = d[82:51];
		r.rec.client       = d[114:83];
		r.rec.sequence_n   = d[146:115];
		r.rec.mask         = d[148:147];
		r.rec.intensity    = d[156:149];
		r.rec.level        = d[164:157];
		r.rec.status       = d[166:165];
		return r;
	endfunction

	function automatic sre_pkg::res_t exchange_step(sre_pkg::item_t it);
		sre_pkg::res_t r;
		sre_pkg::rec_t rq;
		sre_pkg::rec_t req;
		sre_pkg::rec_t res;
		logic        acc;
		logic        dup;
		logic [31:0] d;
		logic [1:0]  chg;
		r = '0;
		rq.session    = it.req_session;
		rq.client     = it.client;
		rq.sequence_n = it.sequence_req;
		rq.mask       = it.change_mask;
		rq.intensity  = it.intensity;
		rq.level      = it.level;
		rq.status     = sre_pkg::ST_OK;
		case (it.op)
			sre_pkg::OP_ANNOUNCE: begin
				if (peer_known && peer_addr != it.peer_address) begin
					req_waiting = 1'b0;
					done_valid = 1'b0;
					reply_waiting = 1'b0;
					newest = '0;
				end
				peer_addr = it.peer_address;
				peer_known = 1'b1;
				peer_seen_at = it.now_ms;
			end
			sre_pkg::OP_REQUEST: begin
				acc = it.decode_ok && peer_known && it.peer_address == peer_addr &&
					peer_fresh(it.now_ms) && rq.session == session_reg;
				if (acc && rq.client != newest.client && rq.mask != 2'd0)
					acc = 1'b0;
				if (acc && rq.client == newest.client && newest.sequence_n != 0) begin
					d = rq.sequence_n - newest.sequence_n;
					if (d[31] || (d == 0 && (rq.mask != newest.mask ||
						rq.intensity != newest.intensity || rq.level != newest.level)))
						acc = 1'b0;
				end
				if (acc) begin
					newest = rq;
					req_waiting = 1'b1;
				end
				r.accepted = acc;
			end
			sre_pkg::OP_PROCESS: begin
				req = newest;
				dup = done_valid && req.client == done_client &&
					req.sequence_n == done_seq && done_reply.status != sre_pkg::ST_BUSY;
				if (req_waiting && peer_fresh(it.now_ms)) begin
					if (dup) begin
						res = done_reply;
					end else begin
						res = req;
						res.status = sre_pkg::ST_OK;
						chg = req.mask;
						if (req.intensity == stored_int) chg[0] = 1'b0;
						if (req.level == stored_lvl) chg[1] = 1'b0;
						if (chg != 2'd0) begin
							if ((cap_reg & chg) != chg) begin
								res.status = sre_pkg::ST_UNSUPP;
							end else if (it.store_outcome == sre_pkg::OUT_OK) begin
								if (chg[0]) stored_int = req.intensity;
								if (chg[1]) stored_lvl = req.level;
							end else begin
								res.status = (it.store_outcome == sre_pkg::OUT_BUSY) ?
									sre_pkg::ST_BUSY : sre_pkg::ST_STORERR;
							end
						end
						res.intensity = stored_int;
						res.level = stored_lvl;
					end
					done_client = req.client;
					done_seq = req.sequence_n;
					done_reply = res;
					done_valid = 1'b1;
					out_reply = res;
					reply_waiting = 1'b1;
					reply_count = reply_count + 1;
					r.reply_posted = 1'b1;
					r.reply_peer = peer_addr;
					r.rec = res;
				end
				req_waiting = 1'b0;
			end
			sre_pkg::OP_POLL: begin
				d = it.now_ms - reply_sent_at;
				if (reply_waiting && peer_fresh(it.now_ms) &&
					(!reply_tried || d >= {16'd0, retry_reg})) begin
					reply_in_flight = reply_count;
					reply_sent_at = it.now_ms;
					reply_tried = 1'b1;
					r.reply_ready = 1'b1;
					r.reply_peer = peer_addr;
					r.rec = out_reply;
				end
			end
			sre_pkg::OP_DONE: begin
				if (it.send_success && reply_in_flight == reply_count)
					reply_waiting = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		sre_pkg::res_t got;
		sre_pkg::res_t want;
		if (!arst_n) begin
			session_reg = '0;
			cap_reg = 2'd3;
			timeout_reg = sre_pkg::TimeoutRst[15:0];
			retry_reg = sre_pkg::RetryRst[15:0];
			peer_addr = '0;
			peer_known = 1'b0;
			peer_seen_at = '0;
			newest = '0;
			req_waiting = 1'b0;
			done_valid = 1'b0;
			done_client = '0;
			done_seq = '0;
			done_reply = '0;
			out_reply = '0;
			reply_waiting = 1'b0;
			reply_tried = 1'b0;
			reply_count = '0;
			reply_in_flight = '0;
			reply_sent_at = '0;
			stored_int = '0;
			stored_lvl = '0;
			expected_results.delete();
			errors = 0;
			n_accepted = 0;
			n_posted = 0;
			n_ready = 0;
		end else begin
			if (m_valid && m_ready) begin
				got = unpack_result(m_data);
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no request waiting: %p", $realtime, got);
				end else begin
					want = expected_results.pop_front();
					if (got.accepted !== want.accepted ||
						got.reply_posted !== want.reply_posted ||
						got.reply_ready !== want.reply_ready ||
						got.reply_peer !== want.reply_peer ||
						got.rec.session !== want.rec.session ||
						got.rec.client !== want.rec.client ||
						got.rec.sequence_n !== want.rec.sequence_n ||
						got.rec.mask !== want.rec.mask ||
						got.rec.intensity !== want.rec.intensity ||
						got.rec.level !== want.rec.level ||
						got.rec.status !== want.rec.status) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch\n  expected %p\n  actual   %p",
								$realtime, want, got);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (sre_pkg::cfg_idx_t'(cfg_index))
					sre_pkg::CFG_SESSION: session_reg = cfg_data;
					sre_pkg::CFG_CAPMASK: cap_reg = cfg_data[1:0];
					sre_pkg::CFG_TIMEOUT: timeout_reg = cfg_data[15:0];
					sre_pkg::CFG_RETRY:   retry_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_valid && s_ready) begin
				want = exchange_step(unpack_event(s_data, s_user));
				n_accepted += want.accepted;
				n_posted += want.reply_posted;
				n_ready += want.reply_ready;
				expected_results.push_back(want);
			end
		end
	end

endmodule

@@ test/tb_top.sv @@
// Testbench top for settings_request_exchange: clock, reset, register phases,
// directed and random event requests with random stalls; verdict from sre_checker.
// Depends on sre_pkg, settings_request_exchange and sre_checker.
module tb_top;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [167:0] m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int errors, pending, n_accepted, n_posted, n_ready;
	int n_sent = 0;
	int n_recv = 0;
	int out_stall = 0;
	bit in_burst = 0;
	bit out_burst = 0;

	logic [31:0] now = 32'd100;
	logic [47:0] cur_peer;
	logic [31:0] cur_session = '0;
	logic [31:0] clients[3];
	logic [31:0] seqs[3];

	settings_request_exchange u_top (.*);

	sre_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_data(s_axis_tdata), .s_user(s_axis_tuser),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending),
		.n_accepted(n_accepted), .n_posted(n_posted), .n_ready(n_ready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		int gap;
		if (m_axis_tvalid && m_axis_tready) begin
			n_recv++;
			if ($urandom_range(0, 99) < 3) out_burst = !out_burst;
			gap = out_burst ? 0 : $urandom_range(0, 13);
			out_stall = gap;
			m_axis_tready <= (gap == 0);
		end else if (out_stall > 0) begin
			out_stall--;
			m_axis_tready <= (out_stall == 0);
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	task automatic send_event(logic [2:0] op, logic [47:0] addr, logic [31:0] t,
		logic dec, logic [31:0] sess, logic [31:0] cli, logic [31:0] sq,
		logic [1:0] mask, logic [7:0] inten, logic [7:0] lvl,
		logic [1:0] outc, logic ss);
		int gap;
		if ($urandom_range(0, 99) < 3) in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'd0, ss, outc, lvl, inten, mask, sq, cli, sess, dec, t, addr};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (n_recv != n_sent) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(sre_pkg::cfg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] sess, logic [1:0] cap, logic [15:0] tmo,
		logic [15:0] rty);
		drain();
		write_reg(sre_pkg::CFG_SESSION, sess);
		write_reg(sre_pkg::CFG_CAPMASK, {30'd0, cap});
		write_reg(sre_pkg::CFG_TIMEOUT, {16'd0, tmo});
		write_reg(sre_pkg::CFG_RETRY, {16'd0, rty});
		cur_session = sess;
	endtask

	task automatic random_event();
		int pick, k;
		logic [2:0]  op;
		logic [47:0] addr;
		logic [31:0] sess, cli, sq;
		logic [7:0]  inten, lvl;
		logic [1:0]  outc;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 2);
		if ($urandom_range(0, 99) < 3)
			now = $urandom();
		else
			now = now + $urandom_range(0, 40);
		addr = ($urandom_range(0, 99) < 92) ? cur_peer : 48'({$urandom(), $urandom()});
		sess = ($urandom_range(0, 99) < 90) ? cur_session : $urandom();
		cli = ($urandom_range(0, 99) < 95) ? clients[k] : $urandom();
		case ($urandom_range(0, 9))
			0: sq = $urandom();
			1: sq = seqs[k] - $urandom_range(1, 3);
			2: sq = 32'd0;
			default: sq = seqs[k] + $urandom_range(0, 2);
		endcase
		inten = ($urandom_range(0, 1)) ? 8'($urandom()) : 8'($urandom_range(0, 3));
		lvl = ($urandom_range(0, 1)) ? 8'($urandom()) : 8'($urandom_range(0, 3));
		outc = ($urandom_range(0, 99) < 70) ? sre_pkg::OUT_OK : 2'($urandom_range(1, 3));
		if (pick < 9) begin
			op = sre_pkg::OP_ANNOUNCE;
			if ($urandom_range(0, 99) < 15) cur_peer = 48'({$urandom(), $urandom()});
			addr = cur_peer;
		end else if (pick < 42) begin
			op = sre_pkg::OP_REQUEST;
			if (sq != seqs[k] && !sq[31]) seqs[k] = sq;
		end else if (pick < 62) begin
			op = sre_pkg::OP_PROCESS;
		end else if (pick < 82) begin
			op = sre_pkg::OP_POLL;
		end else if (pick < 96) begin
			op = sre_pkg::OP_DONE;
		end else begin
			op = 3'($urandom_range(5, 7));
		end
		send_event(op, addr, now, ($urandom_range(0, 99) < 93), sess, cli, sq,
			2'($urandom()), inten, lvl, outc, 1'($urandom()));
	endtask

	initial begin
		logic [47:0] pa;
		logic [47:0] pb;
		pa = 48'h0000_0000_0001;
		pb = 48'hFFFF_FFFF_FFFF;
		cur_peer = pa;
		for (int i = 0; i < 3; i++) begin
			clients[i] = $urandom();
			seqs[i] = $urandom_range(1, 1000);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_event(sre_pkg::OP_PROCESS, pa, 32'd50, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_POLL, pa, 32'd50, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd60, 1, 0, 7, 5, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_ANNOUNCE, pa, 32'd100, 0, 0, 0, 0, 0, 0, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd110, 1, 0, 7, 5, 2'd0, 0, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd111, 1, 0, 7, 5, 2'd3, 8'hFF, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd112, 1, 0, 7, 4, 2'd0, 0, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd113, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_POLL, pa, 32'd114, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_POLL, pa, 32'd120, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_DONE, pa, 32'd121, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_POLL, pa, 32'd140, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_DONE, pa, 32'd141, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 1);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd150, 1, 0, 7, 6, 2'd3, 8'hFF, 8'hFF,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd151, 1, 0, 0, 0, 0, 0, 0, 2'd1, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd152, 1, 0, 7, 6, 2'd3, 8'hFF, 8'hFF,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd153, 1, 0, 0, 0, 0, 0, 0, 2'd3, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd154, 1, 0, 7, 7, 2'd3, 8'hFF, 8'hFF,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd155, 1, 0, 0, 0, 0, 0, 0, 2'd2, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd156, 1, 0, 7, 8, 2'd3, 8'hFF, 8'hFF,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd157, 1, 0, 0, 0, 0, 0, 0, sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pa, 32'd158, 1, 0, 7, 8, 2'd3, 8'hFF, 8'hFF,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pa, 32'd159, 1, 0, 0, 0, 0, 0, 0, 2'd2, 0);
		send_event(3'd5, pb, '1, 1, '1, '1, '1, 2'd3, 8'hFF, 8'hFF, 2'd3, 1);
		send_event(3'd7, pb, '1, 1, '1, '1, '1, 2'd3, 8'hFF, 8'hFF, 2'd3, 1);
		send_event(sre_pkg::OP_ANNOUNCE, pb, 32'hFFFF_FFF0, 1, 0, 0, 0, 0, 0, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_REQUEST, pb, 32'd10, 1, 0, '1, '1, 2'd0, 0, 0,
			sre_pkg::OUT_OK, 0);
		send_event(sre_pkg::OP_PROCESS, pb, 32'd3000, 1, 0, 0, 0, 0, 0, 0,
			sre_pkg::OUT_OK, 0);

		cur_peer = pb;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs($urandom(), 2'd3, 16'd2500, 16'd20);
				1: set_regs(32'd0, 2'd0, 16'd1, 16'd0);
				2: set_regs(32'hFFFF_FFFF, 2'd1, 16'hFFFF, 16'hFFFF);
				3: set_regs($urandom(), 2'd2, 16'($urandom_range(100, 5000)),
					16'($urandom_range(0, 100)));
				default: set_regs($urandom(), 2'd3, 16'd3000, 16'd10);
			endcase
			send_event(sre_pkg::OP_ANNOUNCE, cur_peer, now, 1, 0, 0, 0, 0, 0, 0,
				sre_pkg::OUT_OK, 0);
			for (int i = 0; i < 305; i++) random_event();
		end

		drain();
		$display("Ran %0d event requests over six register settings: %0d accepted,",
			n_sent, n_accepted);
		$display("%0d replies posted, %0d replies handed out for sending.",
			n_posted, n_ready);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding.", n_sent - n_recv);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sre_pkg.sv
hdl/sre_front.sv
hdl/sre_queue.sv
hdl/sre_back.sv
hdl/settings_request_exchange.sv
hdl/sre_checker.sv
test/sre_checker.sv
test/tb_top.sv
